FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds on every clock edge out of reset
`define RLP_ASSERT(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("rlp assertion failed");

// same-cycle implication
`define RLP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rlp assertion failed");

// next-cycle implication
`define RLP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rlp assertion failed");

`else

`define RLP_ASSERT(label, clk, rst, expr)
`define RLP_ASSERT_IMP(label, clk, rst, ante, cons)
`define RLP_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/rlp_pkg.sv
// ----------------------------------------------------------------------------
// rlp_pkg
// shared types and prefix constants of the rlp stream decoder
// ----------------------------------------------------------------------------
package rlp_pkg;

  // parser phase
  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_LENGTH,
    PH_STRING
  } phase_t;

  // result kind
  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_EMPTY,
    KIND_DONE,
    KIND_ERROR
  } kind_t;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_NONCANON,
    ERR_OVERRUN,
    ERR_TRUNC,
    ERR_DEPTH
  } err_t;

  // prefix byte ranges
  localparam logic [7:0] SINGLE_MAX     = 8'h7f;
  localparam logic [7:0] STR_EMPTY      = 8'h80;
  localparam logic [7:0] STR_SHORT_MAX  = 8'hb7;
  localparam logic [7:0] STR_LONG_MAX   = 8'hbf;
  localparam logic [7:0] LIST_EMPTY     = 8'hc0;
  localparam logic [7:0] LIST_SHORT_MAX = 8'hf7;
  // shortest length that may use the long form
  localparam logic [7:0] SHORT_LIMIT    = 8'd56;

  // result queue
  localparam int OUT_DEPTH = 4;
  localparam int PTR_W     = 2;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        first;
    logic        last;
    err_t        code;
    logic        run_last;
  } result_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stack_op_t;

endpackage

FILE: rtl/rlp_out_fifo.sv
// ----------------------------------------------------------------------------
// rlp_out_fifo
// small result queue, takes up to two results a cycle and gives one
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rlp_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             res0_valid,
  input  rlp_pkg::result_t res0,
  input  logic             res1_valid,
  input  rlp_pkg::result_t res1,
  output logic             space_ok,
  output logic             result_valid,
  input  logic             result_ready,
  output rlp_pkg::result_t head
);
  import rlp_pkg::*;

  result_t          store [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic [PTR_W:0]   count_next;
  logic [1:0]       wr_cnt;
  logic             rd;

  assign wr_cnt     = {1'b0, res0_valid} + {1'b0, res1_valid};
  assign rd         = result_valid && result_ready;
  assign count_next = count + {1'b0, wr_cnt} - {{PTR_W{1'b0}}, rd};

  assign result_valid = (count != '0);
  assign head         = store[rd_ptr];
  // room for the worst case of two results from the next request
  assign space_ok     = (count <= (PTR_W+1)'(OUT_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= PTR_W'(wr_ptr + wr_cnt);
      rd_ptr <= PTR_W'(rd_ptr + {{(PTR_W-1){1'b0}}, rd});
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res0_valid) begin
      store[wr_ptr] <= res0;
    end
    if (res1_valid) begin
      store[PTR_W'(wr_ptr + 1'b1)] <= res1;
    end
  end

  `RLP_ASSERT(a_count_bound, clk, rst, count <= (PTR_W+1)'(OUT_DEPTH))
  `RLP_ASSERT(a_no_overflow, clk, rst, count_next <= (PTR_W+1)'(OUT_DEPTH))
  `RLP_ASSERT_IMP(a_second_needs_first, clk, rst, res1_valid, res0_valid)

endmodule

FILE: rtl/rlp_stack.sv
// ----------------------------------------------------------------------------
// rlp_stack
// list end stack: top entry in flops, lower entries in a synchronous memory
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rlp_stack #(
  parameter int MAX_DEPTH = 16,
  parameter int LEN_BITS  = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rlp_pkg::stack_op_t                 op,
  input  logic [LEN_BITS-1:0]                push_end,
  output logic [$clog2(MAX_DEPTH+1)-1:0]     level,
  output logic [LEN_BITS-1:0]                top_end,
  output logic [$clog2(MAX_DEPTH+1)-1:0]     top_drop
);
  import rlp_pkg::*;

  localparam int LVL_W = $clog2(MAX_DEPTH + 1);
  localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  // drop: level left once this list closes, folds lists sharing one end
  typedef struct packed {
    logic [LVL_W-1:0]    drop;
    logic [LEN_BITS-1:0] lim;
  } entry_t;

  entry_t           mem [MAX_DEPTH];
  entry_t           top;
  entry_t           rd_data;
  entry_t           top_cur;
  entry_t           new_ent;
  logic             from_mem;
  logic             rd_en;
  logic             wr_en;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;

  // after a pop the new top arrives from the memory read port
  assign top_cur = from_mem ? rd_data : top;

  assign new_ent.lim  = push_end;
  assign new_ent.drop = (level != '0 && push_end == top_cur.lim) ? top_cur.drop : level;

  assign rd_en   = op.pop && !op.clear && (top_cur.drop != '0);
  assign rd_addr = AW'(top_cur.drop - 1'b1);
  assign wr_en   = op.push && !op.clear && (level != '0);
  assign wr_addr = AW'(level - 1'b1);

  assign top_end  = top_cur.lim;
  assign top_drop = top_cur.drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      level    <= '0;
      from_mem <= 1'b0;
    end else begin
      from_mem <= rd_en;
      if (op.clear) begin
        level <= '0;
      end else if (op.push) begin
        level <= LVL_W'(level + 1'b1);
      end else if (op.pop) begin
        level <= top_cur.drop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op.push) begin
      top <= new_ent;
    end else begin
      top <= top_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= top_cur;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  `RLP_ASSERT(a_push_pop_excl, clk, rst, !(op.push && op.pop))
  `RLP_ASSERT_IMP(a_push_room, clk, rst, op.push && !op.clear, level < LVL_W'(MAX_DEPTH))
  `RLP_ASSERT_IMP(a_pop_below, clk, rst, op.pop && !op.clear, level != '0 && top_cur.drop < level)
  `RLP_ASSERT_NXT(a_pop_level, clk, rst, op.pop && !op.clear, level == $past(top_cur.drop))

endmodule

FILE: rtl/rlp_parse.sv
// ----------------------------------------------------------------------------
// rlp_parse
// per-byte prefix, length and payload decode with list end checks
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rlp_parse #(
  parameter int MAX_DEPTH = 16,
  parameter int LEN_BITS  = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  logic [7:0]                     in_byte,
  input  logic                           message_last,
  input  logic [$clog2(MAX_DEPTH+1)-1:0] level,
  input  logic [LEN_BITS-1:0]            top_end,
  input  logic [$clog2(MAX_DEPTH+1)-1:0] top_drop,
  output rlp_pkg::stack_op_t             op,
  output logic [LEN_BITS-1:0]            push_end,
  output logic                           res0_valid,
  output rlp_pkg::result_t               res0,
  output logic                           res1_valid,
  output rlp_pkg::result_t               res1
);
  import rlp_pkg::*;

  localparam int LVL_W = $clog2(MAX_DEPTH + 1);
  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  phase_t              phase, phase_next;
  logic [LEN_BITS-1:0] offset, offset_next;
  logic [3:0]          len_left, len_left_next;
  logic [LEN_BITS-1:0] acc, acc_next;
  logic                is_list, is_list_next;
  logic [LEN_BITS-1:0] str_left, str_left_next;
  logic                str_first, str_first_next;
  logic                str_single, str_single_next;
  logic                finished, finished_next;

  logic [LEN_BITS-1:0] pos;
  logic [LEN_BITS-1:0] limit;
  logic [LEN_BITS-1:0] room;
  logic [LEN_BITS-1:0] acc_new;
  logic [LEN_BITS-1:0] item_len;
  logic                at_end;
  logic                take;
  logic                want_open;
  logic                open_is_list;
  logic                done;
  logic                completion;
  logic                fail;
  err_t                fail_code;
  logic                emit_data;
  logic                emit_empty;
  logic                d_first;
  logic                d_last;
  logic                trunc;
  logic                has_p;
  logic                has_q;
  result_t             res_p;
  result_t             res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_PREFIX;
      offset     <= '0;
      len_left   <= '0;
      acc        <= '0;
      is_list    <= 1'b0;
      str_left   <= '0;
      str_first  <= 1'b0;
      str_single <= 1'b0;
      finished   <= 1'b0;
    end else begin
      phase      <= phase_next;
      offset     <= offset_next;
      len_left   <= len_left_next;
      acc        <= acc_next;
      is_list    <= is_list_next;
      str_left   <= str_left_next;
      str_first  <= str_first_next;
      str_single <= str_single_next;
      finished   <= finished_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    offset_next     = offset;
    len_left_next   = len_left;
    acc_next        = acc;
    is_list_next    = is_list;
    str_left_next   = str_left;
    str_first_next  = str_first;
    str_single_next = str_single;

    pos      = LEN_BITS'(offset + 1'b1);
    limit    = (level == '0) ? LEN_MAX : top_end;
    room     = limit - pos;
    at_end   = (level != '0) && (top_end == pos);
    acc_new  = LEN_BITS'({acc, in_byte});
    item_len = '0;

    take         = fire && !finished;
    want_open    = 1'b0;
    open_is_list = 1'b0;
    done         = 1'b0;
    completion   = 1'b0;
    fail         = 1'b0;
    fail_code    = ERR_NONE;
    emit_data    = 1'b0;
    emit_empty   = 1'b0;
    d_first      = 1'b0;
    d_last       = 1'b0;
    op           = '0;
    push_end     = LEN_BITS'(pos + item_len);

    if (take) begin
      offset_next = pos;
      case (phase)
        PH_PREFIX: begin
          if (in_byte <= SINGLE_MAX) begin
            emit_data = 1'b1;
            d_first   = 1'b1;
            d_last    = 1'b1;
            done      = 1'b1;
          end else if (in_byte == STR_EMPTY) begin
            emit_empty = 1'b1;
            done       = 1'b1;
          end else if (in_byte <= STR_SHORT_MAX) begin
            want_open = 1'b1;
            item_len  = LEN_BITS'(in_byte - STR_EMPTY);
          end else if (in_byte <= STR_LONG_MAX) begin
            phase_next    = PH_LENGTH;
            len_left_next = 4'(in_byte - STR_SHORT_MAX);
            is_list_next  = 1'b0;
            acc_next      = '0;
          end else if (in_byte == LIST_EMPTY) begin
            done = 1'b1;
          end else if (in_byte <= LIST_SHORT_MAX) begin
            want_open    = 1'b1;
            open_is_list = 1'b1;
            item_len     = LEN_BITS'(in_byte - LIST_EMPTY);
          end else begin
            phase_next    = PH_LENGTH;
            len_left_next = 4'(in_byte - LIST_SHORT_MAX);
            is_list_next  = 1'b1;
            acc_next      = '0;
          end
        end
        PH_LENGTH: begin
          if (offset >= limit) begin
            fail      = 1'b1;
            fail_code = ERR_OVERRUN;
          end else if (acc == '0 && in_byte == 8'h00) begin
            fail      = 1'b1;
            fail_code = ERR_NONCANON;
          end else if ((acc >> (LEN_BITS - 8)) != '0) begin
            fail      = 1'b1;
            fail_code = ERR_OVERRUN;
          end else begin
            acc_next = acc_new;
            if (len_left != '0) begin
              len_left_next = len_left - 1'b1;
            end
            if (len_left <= 4'd1) begin
              if (acc_new < LEN_BITS'(SHORT_LIMIT)) begin
                fail      = 1'b1;
                fail_code = ERR_NONCANON;
              end else begin
                want_open    = 1'b1;
                open_is_list = is_list;
                item_len     = acc_new;
              end
            end
          end
        end
        PH_STRING: begin
          if (str_first && str_single && in_byte < STR_EMPTY) begin
            fail      = 1'b1;
            fail_code = ERR_NONCANON;
          end else begin
            emit_data      = 1'b1;
            d_first        = str_first;
            d_last         = (str_left <= LEN_BITS'(1));
            str_first_next = 1'b0;
            if (str_left != '0) begin
              str_left_next = str_left - 1'b1;
            end
            if (str_left <= LEN_BITS'(1)) begin
              done = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase

      // string or list start: bound by the enclosing list end
      if (want_open) begin
        push_end = LEN_BITS'(pos + item_len);
        if (item_len > room) begin
          fail      = 1'b1;
          fail_code = ERR_OVERRUN;
        end else if (open_is_list) begin
          if (level >= LVL_W'(MAX_DEPTH)) begin
            fail      = 1'b1;
            fail_code = ERR_DEPTH;
          end else begin
            op.push    = 1'b1;
            phase_next = PH_PREFIX;
          end
        end else begin
          phase_next      = PH_STRING;
          str_left_next   = item_len;
          acc_next        = item_len;
          str_first_next  = 1'b1;
          str_single_next = (item_len == LEN_BITS'(1));
        end
      end

      // item closed: pop every list ending here in one step
      if (done) begin
        phase_next = PH_PREFIX;
        op.pop     = at_end;
        completion = at_end ? (top_drop == '0) : (level == '0);
      end
    end

    trunc         = fire && message_last && !finished && !fail && !completion;
    finished_next = finished || fail || completion;

    // last byte of the message: back to the reset state
    if (fire && message_last) begin
      op.clear        = 1'b1;
      phase_next      = PH_PREFIX;
      offset_next     = '0;
      len_left_next   = '0;
      acc_next        = '0;
      is_list_next    = 1'b0;
      str_left_next   = '0;
      str_first_next  = 1'b0;
      str_single_next = 1'b0;
      finished_next   = 1'b0;
    end

    has_p          = emit_data || emit_empty;
    res_p.kind     = emit_data ? KIND_DATA : KIND_EMPTY;
    res_p.data     = emit_data ? in_byte : 8'h00;
    res_p.first    = d_first;
    res_p.last     = d_last;
    res_p.code     = ERR_NONE;
    res_p.run_last = 1'b0;

    has_q          = fail || completion || trunc;
    res_q.kind     = completion ? KIND_DONE : KIND_ERROR;
    res_q.data     = 8'h00;
    res_q.first    = 1'b0;
    res_q.last     = 1'b0;
    res_q.code     = fail ? fail_code : (completion ? ERR_NONE : ERR_TRUNC);
    res_q.run_last = 1'b1;

    res0_valid     = has_p || has_q;
    res0           = has_p ? res_p : res_q;
    res0.run_last  = !(has_p && has_q);
    res1_valid     = has_p && has_q;
    res1           = res_q;
  end

  `RLP_ASSERT_IMP(a_str_live, clk, rst, phase == PH_STRING && !finished, str_left != '0)
  `RLP_ASSERT_IMP(a_len_live, clk, rst, phase == PH_LENGTH && !finished, len_left != '0)
  `RLP_ASSERT_NXT(a_msg_restart, clk, rst, fire && message_last, offset == '0 && !finished && phase == PH_PREFIX)

endmodule

FILE: rtl/rlp_stream_decoder.sv
// ----------------------------------------------------------------------------
// rlp_stream_decoder
// streaming recursive-length-prefix decoder with flattened list output
//
// byte channel: byte_valid/byte_ready carry one raw message byte per request,
// message_last marks the final byte; the decoder restarts after it
// result channel: result_valid/result_ready carry one result per request,
// data bytes of each string item (first/last marked), empty strings, one
// completion for the top-level item, or an error that ends the message;
// run_last flags the last result caused by a byte
// results of a byte are registered in the result queue before they are offered
// throughput: one byte per cycle while byte_ready is high; a byte giving two
// results hands them out one at a time through the single output port of the queue
// the list end stack keeps its top in flops and lower levels in a memory
// with a registered read port; a pop reads the next level, which is used
// straight from the read port and then held in the top entry
// reset: synchronous, clears parser state, the stack level and the result queue, no sweep
// stall: a four-entry result queue keeps taking bytes while at most two
// results wait; byte_ready drops only when the queue cannot take two more
// bytes after the top-level item or an error produce nothing until the
// byte marked message_last
// ----------------------------------------------------------------------------
module rlp_stream_decoder #(
  parameter int MAX_DEPTH = 16,
  parameter int LEN_BITS  = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] in_byte,
  input  logic       message_last,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [1:0] result_kind,
  output logic [7:0] data_byte,
  output logic       item_first,
  output logic       item_last,
  output logic [2:0] error_code,
  output logic       run_last
);
  import rlp_pkg::*;

  localparam int LVL_W = $clog2(MAX_DEPTH + 1);

  logic                fire;
  stack_op_t           op;
  logic [LEN_BITS-1:0] push_end;
  logic [LVL_W-1:0]    level;
  logic [LEN_BITS-1:0] top_end;
  logic [LVL_W-1:0]    top_drop;
  logic                res0_valid;
  logic                res1_valid;
  result_t             res0;
  result_t             res1;
  result_t             head;

  // byte request taken
  assign fire = byte_valid && byte_ready;

  rlp_parse #(
    .MAX_DEPTH (MAX_DEPTH),
    .LEN_BITS  (LEN_BITS)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .in_byte      (in_byte),
    .message_last (message_last),
    .level        (level),
    .top_end      (top_end),
    .top_drop     (top_drop),
    .op           (op),
    .push_end     (push_end),
    .res0_valid   (res0_valid),
    .res0         (res0),
    .res1_valid   (res1_valid),
    .res1         (res1)
  );

  // open list ends, read-modify-write through the top entry
  rlp_stack #(
    .MAX_DEPTH (MAX_DEPTH),
    .LEN_BITS  (LEN_BITS)
  ) u_stack (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .push_end (push_end),
    .level    (level),
    .top_end  (top_end),
    .top_drop (top_drop)
  );

  // result queue doubles as the output register
  rlp_out_fifo u_out (
    .clk          (clk),
    .rst          (rst),
    .res0_valid   (res0_valid),
    .res0         (res0),
    .res1_valid   (res1_valid),
    .res1         (res1),
    .space_ok     (byte_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .head         (head)
  );

  // unpack the head result onto the field ports
  assign result_kind = head.kind;
  assign data_byte   = head.data;
  assign item_first  = head.first;
  assign item_last   = head.last;
  assign error_code  = head.code;
  assign run_last    = head.run_last;

endmodule
